FILE: src/mpsf_pkg.sv
`timescale 1ns / 1ps
// Package for the MPEG packet sync filter: beat types, stream modes, packet constants.
// No dependencies.
package mpsf_pkg;

    localparam int MaxPacket  = 2048;
    localparam int TsPacket   = 188;
    localparam int StoreDepth = 2 * MaxPacket + 4;
    localparam int SlotW      = $clog2(StoreDepth);
    localparam int PosW       = $clog2(MaxPacket);

    localparam logic [1:0] MODE_RAW = 2'd0;
    localparam logic [1:0] MODE_TS  = 2'd1;
    localparam logic [1:0] MODE_PS  = 2'd2;

    localparam logic [7:0] TS_SYNC     = 8'h47;
    localparam logic [7:0] PS_CODE_END = 8'hBA;
    localparam logic [7:0] PS_CODE_ONE = 8'h01;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       sample_end;
    } t_in_beat;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        packet_end;
        logic [31:0] error_count;
    } t_out_beat;

endpackage

FILE: src/mpeg_packet_sync_filter_top.sv
`timescale 1ns / 1ps
// MPEG packet sync filter top level: alignment state machine and marker history store.
// Depends on mpsf_pkg.
//
// Accepts one byte per clock unless the output stalls, and returns at most one byte
// per accepted byte. A byte waits in the input register while the marker history
// store is read, then goes to the output register; without stalls the sustained rate
// is one byte per cycle through the single input-to-output pass. The store keeps one
// start-marker flag per received byte (4100 entries, read at one and two packet
// lengths back), so no clearing pass is needed after reset. Program mode outputs
// bytes three bytes late, since a pack code is only seen on its fourth byte.
module mpeg_packet_sync_filter_top
    import mpsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_beat   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_beat  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam logic [SlotW-1:0] DEPTH_S  = SlotW'(StoreDepth);
    localparam logic [SlotW-1:0] TS_S     = SlotW'(TsPacket);
    localparam logic [SlotW-1:0] PS_S     = SlotW'(MaxPacket);
    localparam logic [PosW:0]    TS_P     = (PosW+1)'(TsPacket);
    localparam logic [PosW:0]    PS_P     = (PosW+1)'(MaxPacket);
    localparam logic [SlotW-1:0] TS_LOCK  = SlotW'(2 * TsPacket);
    localparam logic [SlotW-1:0] PS_LOCK  = SlotW'(2 * MaxPacket + 3);

    logic r_mem [StoreDepth];

    logic [1:0]       r_mode;
    logic [7:0]       r_h1, r_h2, r_h3;
    logic [SlotW-1:0] r_wslot;

    logic             r_in_valid;
    t_in_beat         r_in;
    logic [7:0]       r_lag;
    logic             r_m, r_f1, r_f2;

    logic [SlotW-1:0] r_fill;
    logic             r_locked, r_acc, r_rev;
    logic [PosW:0]    r_bip;
    logic [31:0]      r_drop;

    logic             r_out_valid;
    t_out_beat        r_out;

    logic             acc_in, proc;
    logic             is_ps, is_raw, flag_now;
    logic [SlotW-1:0] p_s, rd1, rd2, n_wslot;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign proc        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || proc;
    assign acc_in      = i_in_valid && o_in_ready;

    assign is_ps  = (r_mode == MODE_PS);
    assign is_raw = (r_mode != MODE_TS) && (r_mode != MODE_PS);
    assign p_s    = is_ps ? PS_S : TS_S;

    always_comb begin
        if (is_ps) begin
            flag_now = (r_h3 == 8'd0) && (r_h2 == 8'd0) && (r_h1 == PS_CODE_ONE)
                       && (i_in_data.in_byte == PS_CODE_END);
        end else begin
            flag_now = (i_in_data.in_byte == TS_SYNC);
        end
        rd1 = (r_wslot >= p_s) ? r_wslot - p_s : r_wslot + DEPTH_S - p_s;
        rd2 = (rd1 >= p_s) ? rd1 - p_s : rd1 + DEPTH_S - p_s;
        n_wslot = (r_wslot == DEPTH_S - 1'b1) ? '0 : r_wslot + 1'b1;
    end

    // history store: write the new flag, read one and two packets back
    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_mem[r_wslot] <= flag_now;
            r_f1           <= r_mem[rd1];
            r_f2           <= r_mem[rd2];
            r_m            <= flag_now;
            r_lag          <= r_h3;
            r_in           <= i_in_data;
            r_h1           <= i_in_data.in_byte;
            r_h2           <= r_h1;
            r_h3           <= r_h2;
        end
    end

    // process stage next state
    logic             n_locked, n_acc, n_rev, n_emit;
    logic [SlotW-1:0] n_fill;
    logic [PosW:0]    n_bip, pos, p_p, c_p;
    logic [31:0]      n_drop;
    t_out_beat        n_out;
    logic             trip, ok;
    logic [SlotW-1:0] lock_fill, c_s;

    always_comb begin
        n_locked  = r_locked;
        n_acc     = r_acc;
        n_rev     = r_rev;
        n_bip     = r_bip;
        n_drop    = r_drop;
        n_emit    = 1'b0;
        n_out     = r_out;
        p_p       = is_ps ? PS_P : TS_P;
        c_p       = is_ps ? (PosW+1)'(3) : '0;
        c_s       = is_ps ? SlotW'(3) : '0;
        lock_fill = is_ps ? PS_LOCK : TS_LOCK;
        trip      = r_m && r_f1 && r_f2;
        ok        = 1'b0;
        pos       = '0;
        if (is_raw) begin
            n_emit            = 1'b1;
            n_out.out_byte    = r_in.in_byte;
            n_out.packet_end  = r_in.sample_end;
            n_out.error_count = r_drop;
        end else begin
            if (!r_locked) begin
                if (r_fill >= lock_fill && trip) begin
                    n_locked = 1'b1;
                    n_bip    = c_p;
                    n_acc    = 1'b1;
                    n_rev    = 1'b0;
                end
            end else if (r_bip == c_p) begin
                if (r_rev && r_fill >= c_s) begin
                    if (r_fill >= lock_fill) begin
                        ok = trip;
                        if (ok) begin
                            n_rev = 1'b0;
                        end
                    end else begin
                        ok = r_m;
                    end
                    if (ok) begin
                        n_acc = 1'b1;
                    end else begin
                        n_locked = 1'b0;
                        n_rev    = 1'b0;
                        n_acc    = 1'b0;
                    end
                end else begin
                    n_acc = r_m;
                end
            end
            if (n_locked) begin
                pos = (n_bip < p_p) ? n_bip : '0;
                if (n_acc) begin
                    if (pos == (is_ps ? (PosW+1)'(2) : TS_P - 1'b1)) begin
                        n_out.packet_end = 1'b1;
                    end else begin
                        n_out.packet_end = 1'b0;
                    end
                    n_emit         = 1'b1;
                    n_out.out_byte = is_ps ? r_lag : r_in.in_byte;
                end
                // count a dropped packet on its last byte, except a short carried one
                if (pos == p_p - 1'b1 && !n_acc
                    && !(n_rev && r_fill < SlotW'(p_p - 1'b1))
                    && r_drop != 32'hFFFF_FFFF) begin
                    n_drop = r_drop + 1'b1;
                end
                n_bip = (pos + 1'b1 == p_p) ? '0 : pos + 1'b1;
            end
            n_out.error_count = n_drop;
        end
        if (r_in.sample_end) begin
            n_fill = '0;
            if (n_locked) begin
                n_rev = 1'b1;
            end
        end else begin
            n_fill = (r_fill < DEPTH_S) ? r_fill + 1'b1 : DEPTH_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TS;
            r_wslot     <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_locked    <= 1'b0;
            r_acc       <= 1'b0;
            r_rev       <= 1'b0;
            r_bip       <= '0;
            r_drop      <= '0;
        end else begin
            if (acc_in) begin
                r_wslot <= n_wslot;
            end
            if (acc_in) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= n_emit;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // mode write: back to hunting, keep the error count
            if (i_cfg_valid) begin
                r_mode   <= i_cfg_data;
                r_fill   <= '0;
                r_locked <= 1'b0;
                r_acc    <= 1'b0;
                r_rev    <= 1'b0;
                r_bip    <= '0;
            end else if (proc) begin
                r_fill   <= n_fill;
                r_locked <= n_locked;
                r_acc    <= n_acc;
                r_rev    <= n_rev;
                r_bip    <= n_bip;
                r_drop   <= n_drop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && n_emit) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: tb/sv/mpsf_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MPEG packet sync filter: watches the input, output and mode channels,
// predicts each output beat from its own alignment state and compares. Depends on mpsf_pkg.
module mpsf_checker
    import mpsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  t_in_beat   i_in_data,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  t_out_beat  i_out_data,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [1:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_beats_owed
);

    logic [7:0]  byte_hist [StoreDepth];
    int          hist_slot;
    int          sample_fill;
    bit          in_lock;
    int          pkt_pos;
    bit          pkt_keep;
    bit          recheck;
    logic [31:0] drop_count;
    logic [1:0]  cur_mode;
    t_out_beat   owed_beats [$];

    initial begin
        o_fail_count = 0;
        o_beats_owed = 0;
        hist_slot = 0;
        foreach (byte_hist[i]) byte_hist[i] = 8'h00;
    end

    function automatic logic [7:0] byte_back(logic [7:0] cur, int k);
        if (k == 0) return cur;
        return byte_hist[(hist_slot + StoreDepth - k) % StoreDepth];
    endfunction

    function automatic bit sync_at(logic [7:0] cur, int e, bit ps);
        if (!ps) return byte_back(cur, e) == TS_SYNC;
        return byte_back(cur, e + 3) == 8'h00 && byte_back(cur, e + 2) == 8'h00 &&
               byte_back(cur, e + 1) == PS_CODE_ONE && byte_back(cur, e) == PS_CODE_END;
    endfunction

    function automatic bit three_syncs(logic [7:0] cur, int plen, bit ps);
        return sync_at(cur, 0, ps) && sync_at(cur, plen, ps) && sync_at(cur, 2 * plen, ps);
    endfunction

    function automatic void drop_alignment();
        sample_fill = 0;
        in_lock = 0;
        pkt_pos = 0;
        pkt_keep = 0;
        recheck = 0;
    endfunction

    function automatic void store_byte(logic [7:0] b, int fb, logic se);
        byte_hist[hist_slot] = b;
        hist_slot = (hist_slot + 1) % StoreDepth;
        if (se) begin
            sample_fill = 0;
            if (in_lock) recheck = 1;
        end else begin
            sample_fill = (fb < StoreDepth) ? fb + 1 : StoreDepth;
        end
    endfunction

    // Advance the alignment state by one byte; returns 1 when a beat leaves.
    function automatic bit align_byte(t_in_beat ib, output t_out_beat ob);
        logic [7:0] b;
        int fb, plen, lag, pos;
        bit ps, hit, ok, sent;
        b = ib.in_byte;
        fb = sample_fill;
        sent = 0;
        ob = '0;
        if (cur_mode != MODE_TS && cur_mode != MODE_PS) begin
            ob.out_byte = b;
            ob.packet_end = ib.sample_end;
            ob.error_count = drop_count;
            store_byte(b, fb, ib.sample_end);
            return 1;
        end
        ps = (cur_mode == MODE_PS);
        plen = ps ? MaxPacket : TsPacket;
        lag = ps ? 3 : 0;
        if (!in_lock) begin
            if (fb >= 2 * plen + lag && three_syncs(b, plen, ps)) begin
                in_lock = 1;
                pkt_pos = lag;
                pkt_keep = 1;
                recheck = 0;
            end
        end else if (pkt_pos == lag) begin
            hit = sync_at(b, 0, ps);
            if (recheck && fb >= lag) begin
                if (fb >= 2 * plen + lag) begin
                    ok = hit && three_syncs(b, plen, ps);
                    if (ok) recheck = 0;
                end else begin
                    ok = hit;
                end
                if (ok) begin
                    pkt_keep = 1;
                end else begin
                    in_lock = 0;
                    recheck = 0;
                    pkt_keep = 0;
                end
            end else begin
                pkt_keep = hit;
            end
        end
        if (in_lock) begin
            pos = (pkt_pos < plen) ? pkt_pos : 0;
            if (pkt_keep) begin
                ob.out_byte = byte_back(b, lag);
                ob.packet_end = (pos == (lag + plen - 1) % plen);
                sent = 1;
            end
            if (pos == plen - 1 && !pkt_keep && !(recheck && fb < plen - 1) &&
                drop_count != 32'hFFFF_FFFF)
                drop_count++;
            pkt_pos = (pos + 1 == plen) ? 0 : pos + 1;
        end
        ob.error_count = drop_count;
        store_byte(b, fb, ib.sample_end);
        return sent;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want, got;
        if (!i_rst_n) begin
            cur_mode = MODE_TS;
            drop_count = '0;
            hist_slot = 0;
            drop_alignment();
            owed_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (owed_beats.size() == 0) begin
                    $error("unexpected output beat: byte %0h end %0b count %0d",
                           got.out_byte, got.packet_end, got.error_count);
                    o_fail_count++;
                end else begin
                    want = owed_beats.pop_front();
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                        o_fail_count++;
                    end
                    if (got.packet_end !== want.packet_end) begin
                        $error("packet_end: expected %0b, got %0b",
                               want.packet_end, got.packet_end);
                        o_fail_count++;
                    end
                    if (got.error_count !== want.error_count) begin
                        $error("error_count: expected %0d, got %0d",
                               want.error_count, got.error_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cur_mode = i_cfg_data;
                drop_alignment();
            end
            if (i_in_valid && i_in_ready) begin
                if (align_byte(i_in_data, want)) owed_beats = {owed_beats, want};
            end
        end
        o_beats_owed = owed_beats.size();
    end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the MPEG packet sync filter testbench: clock, reset, byte stimulus, mode writes
// and verdict. Depends on mpsf_pkg, mpsf_checker and mpeg_packet_sync_filter_top.
module testbench;
    import mpsf_pkg::*;

    localparam int CycleLimit = 1_000_000;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    t_in_beat   in_data;
    logic       out_valid;
    logic       out_ready;
    t_out_beat  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         fail_count;
    int         beats_owed;
    int         cycle_count = 0;
    int         burst_left;

    mpeg_packet_sync_filter_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    mpsf_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_beats_owed (beats_owed)
    );

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("mpeg_packet_sync_filter_top test failed");
            $finish;
        end
    end

    // Receiver: alternate stretches of steady ready with stretches of random stalls.
    initial begin
        int stretch;
        bit choppy;
        out_ready = 0;
        forever begin
            stretch = $urandom_range(5, 60);
            choppy = $urandom_range(0, 1);
            repeat (stretch) begin
                @(negedge clk);
                out_ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic se);
        if (burst_left == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid <= 1;
        in_data <= '{in_byte: b, sample_end: se};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        burst_left--;
    endtask

    // Hold input until every owed beat is out, then let the pipeline settle.
    task automatic drain();
        in_valid <= 0;
        burst_left = 0;
        @(negedge clk);
        while (beats_owed != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        cfg_valid <= 1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // One packet or pack; a corrupt start breaks the marker, sample end may fall anywhere.
    task automatic send_packet(input bit ps, input bit corrupt, input int se_pct);
        int plen;
        logic [7:0] b;
        logic se;
        plen = ps ? MaxPacket : TsPacket;
        for (int i = 0; i < plen; i++) begin
            b = $urandom_range(0, 255);
            if (ps && i < 4) b = (i == 3) ? PS_CODE_END : (i == 2) ? PS_CODE_ONE : 8'h00;
            if (!ps && i == 0) b = TS_SYNC;
            if (corrupt && i == (ps ? 3 : 0)) b = b ^ (8'h01 << $urandom_range(0, 7));
            se = ($urandom_range(0, 9999) < se_pct);
            send_beat(b, se);
        end
    endtask

    task automatic send_noise(input int n);
        repeat (n) send_beat($urandom_range(0, 255), $urandom_range(0, 19) == 0);
    endtask

    initial begin
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_valid = 0;
        cfg_data = MODE_RAW;
        burst_left = 0;
        repeat (12) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // Directed: pass-through extremes, then the unused selector value.
        write_mode(MODE_RAW);
        send_beat(8'h00, 1);
        send_beat(8'hFF, 0);
        send_beat(8'h55, 0);
        send_beat(8'hAA, 1);
        send_beat(TS_SYNC, 0);
        write_mode(2'd3);
        send_beat(8'hFF, 1);
        send_beat(8'h00, 0);
        send_beat(8'h80, 1);

        // Transport: lock, a dropped packet, then a boundary that slips the alignment.
        write_mode(MODE_TS);
        send_noise(5);
        repeat (3) send_packet(0, 0, 0);
        send_packet(0, 1, 0);
        send_packet(0, 0, 0);
        send_beat(8'h11, 1);
        drain();

        // Transport, still aligned state: recheck fails, hunt again, occasional boundaries.
        for (int n = 0; n < 3; n++) begin
            send_packet(0, $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0 ? 40 : 0);
        end

        // Program: hunting only, nothing leaves.
        write_mode(MODE_PS);
        send_beat(8'h00, 0);
        send_beat(8'h00, 0);
        send_beat(PS_CODE_ONE, 0);
        send_beat(PS_CODE_END, 0);
        send_noise(20);

        write_mode(2'd3);
        send_noise(12);

        drain();
        if (fail_count == 0) begin
            $display("mpeg_packet_sync_filter_top test passed");
        end else begin
            $display("mpeg_packet_sync_filter_top test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/mpsf_pkg.sv
src/mpeg_packet_sync_filter_top.sv
tb/sv/mpsf_checker.sv
tb/sv/testbench.sv
